/* rtl/keypad_scan_debounce_4x4_macros.svh */
// Assertion macros shared by the keypad scanner checker.
`ifndef KEYPAD_SCAN_DEBOUNCE_4X4_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_4X4_MACROS_SVH

// Immediate-implication check, sampled on clk, quiet during reset.
`define KPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, sampled on clk, quiet during reset.
`define KPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kpd_pkg.sv */
`default_nettype none
package kpd_pkg;

  localparam int KPD_KEY_W   = 5;
  localparam int KPD_CHAR_W  = 8;
  localparam int KPD_SNAP_W  = 16;
  localparam int KPD_Q_DEPTH = 2;
  localparam int KPD_Q_AW    = $clog2(KPD_Q_DEPTH);
  localparam int KPD_Q_CW    = $clog2(KPD_Q_DEPTH + 1);

  localparam logic [KPD_KEY_W-1:0]  KPD_NO_KEY = '0;
  localparam logic [KPD_CHAR_W-1:0] KPD_DC1    = 8'h11;
  localparam logic [KPD_CHAR_W-1:0] KPD_DC2    = 8'h12;
  localparam logic [KPD_CHAR_W-1:0] KPD_DC3    = 8'h13;
  localparam logic [KPD_CHAR_W-1:0] KPD_DC4    = 8'h14;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_EDGE     = 2'd1,
    PH_VERIFIED = 2'd2
  } kpd_phase_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kpd_q_stat_t;

  // Position of the highest set column plus one; zero for an empty row.
  function automatic logic [2:0] kpd_top_col(input logic [3:0] cols);
    logic [2:0] pos;
    pos = 3'd0;
    if (cols[3]) begin
      pos = 3'd4;
    end else if (cols[2]) begin
      pos = 3'd3;
    end else if (cols[1]) begin
      pos = 3'd2;
    end else if (cols[0]) begin
      pos = 3'd1;
    end
    return pos;
  endfunction

  // Topmost row with a pressed key wins; rows are scanned bottom up so the
  // last hit overrides.
  function automatic logic [KPD_KEY_W-1:0] kpd_encode(input logic [KPD_SNAP_W-1:0] snap);
    logic [KPD_KEY_W-1:0] key;
    logic [3:0]           cols;
    key = KPD_NO_KEY;
    for (int r = 3; r >= 0; r--) begin
      cols = snap[4*r +: 4];
      if (cols != 4'd0) begin
        key = KPD_KEY_W'(4 * r) + KPD_KEY_W'(kpd_top_col(cols));
      end
    end
    return key;
  endfunction

  function automatic logic [KPD_CHAR_W-1:0] kpd_char(input logic [KPD_KEY_W-1:0] num);
    logic [3:0]            idx;
    logic [KPD_CHAR_W-1:0] ch;
    idx = 4'(num - 5'd1);
    case (idx)
      4'd0:    ch = "1";
      4'd1:    ch = "2";
      4'd2:    ch = "3";
      4'd3:    ch = KPD_DC1;
      4'd4:    ch = "4";
      4'd5:    ch = "5";
      4'd6:    ch = "6";
      4'd7:    ch = KPD_DC2;
      4'd8:    ch = "7";
      4'd9:    ch = "8";
      4'd10:   ch = "9";
      4'd11:   ch = KPD_DC3;
      4'd12:   ch = "*";
      4'd13:   ch = "0";
      4'd14:   ch = "#";
      default: ch = KPD_DC4;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

/* rtl/keypad_scan_debounce_4x4.sv */
// Channel   Direction  Handshake         Payload
// in_       input      in_valid/in_stall  in_pressed_keys[15:0]
// out_      output     out_valid/out_stall out_key_char[7:0], out_key_number[4:0]
//
// One scan is taken per cycle while in_stall is low; an accepted scan is registered
// in the queue before any result reaches the output register. The encoder feeds a
// two-entry queue, and the debounce machine drains one entry per cycle into the
// output register. Synchronous reset clears the queue, the debounce phase and the
// output valid. An output stall holds a valid result and stops the drain; in_stall
// rises only once the queue is full.
`default_nettype none
module keypad_scan_debounce_4x4 import kpd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KPD_SNAP_W-1:0] in_pressed_keys,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [KPD_CHAR_W-1:0]      out_key_char,
  output logic [KPD_KEY_W-1:0]       out_key_number
);

  kpd_q_stat_t          q_stat;
  logic                 push;
  logic [KPD_KEY_W-1:0] push_key;
  logic                 pop;
  logic [KPD_KEY_W-1:0] pop_key;

  kpd_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pressed_keys (in_pressed_keys),
    .q_stat          (q_stat),
    .push            (push),
    .push_key        (push_key)
  );

  kpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_key (push_key),
    .pop      (pop),
    .pop_key  (pop_key),
    .q_stat   (q_stat)
  );

  kpd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_key        (pop_key),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_char   (out_key_char),
    .out_key_number (out_key_number)
  );

endmodule
`default_nettype wire

/* rtl/kpd_front.sv */
`default_nettype none
module kpd_front import kpd_pkg::*; (
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KPD_SNAP_W-1:0] in_pressed_keys,
  input  wire kpd_q_stat_t           q_stat,
  output logic                       push,
  output logic [KPD_KEY_W-1:0]       push_key
);

  // The stall looks only at the queue's registered fill level.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign push_key = kpd_encode(in_pressed_keys);

endmodule
`default_nettype wire

/* rtl/kpd_queue.sv */
`default_nettype none
module kpd_queue import kpd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [KPD_KEY_W-1:0] push_key,
  input  wire logic                 pop,
  output logic [KPD_KEY_W-1:0]      pop_key,
  output kpd_q_stat_t               q_stat
);

  logic [KPD_KEY_W-1:0] mem_r [KPD_Q_DEPTH];
  logic [KPD_Q_AW-1:0]  wr_ptr_r;
  logic [KPD_Q_AW-1:0]  rd_ptr_r;
  logic [KPD_Q_CW-1:0]  cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign q_stat.full  = (cnt_r == KPD_Q_CW'(KPD_Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_key      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/kpd_back.sv */
`default_nettype none
module kpd_back import kpd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kpd_q_stat_t          q_stat,
  input  wire logic [KPD_KEY_W-1:0] pop_key,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [KPD_CHAR_W-1:0]     out_key_char,
  output logic [KPD_KEY_W-1:0]      out_key_number
);

  kpd_phase_t           phase_r, phase_nxt;
  logic [KPD_KEY_W-1:0] prev_key_r, prev_key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [KPD_CHAR_W-1:0] char_r, char_nxt;
  logic [KPD_KEY_W-1:0] num_r, num_nxt;
  logic                 emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RELEASED;
      prev_key_r  <= KPD_NO_KEY;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      prev_key_r  <= prev_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    num_r  <= num_nxt;
  end

  always_comb begin
    // A queued scan is taken whenever the output register is free or draining.
    pop           = !q_stat.empty && (!out_valid_r || !out_stall);
    phase_nxt     = phase_r;
    prev_key_nxt  = prev_key_r;
    emit          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    char_nxt      = char_r;
    num_nxt       = num_r;
    if (pop) begin
      prev_key_nxt = pop_key;
      case (phase_r)
        PH_RELEASED: begin
          if (pop_key != KPD_NO_KEY) begin
            phase_nxt = PH_EDGE;
          end
        end
        PH_EDGE: begin
          if (pop_key == KPD_NO_KEY) begin
            phase_nxt = PH_RELEASED;
          end else if (pop_key == prev_key_r) begin
            phase_nxt = PH_VERIFIED;
            emit      = 1'b1;
          end
        end
        PH_VERIFIED: begin
          if (pop_key == KPD_NO_KEY || pop_key != prev_key_r) begin
            phase_nxt = PH_RELEASED;
          end
        end
        default: begin
          phase_nxt = PH_RELEASED;
        end
      endcase
      out_valid_nxt = emit;
      if (emit) begin
        char_nxt = kpd_char(pop_key);
        num_nxt  = pop_key;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_char   = char_r;
  assign out_key_number = num_r;

endmodule
`default_nettype wire

/* rtl/kpd_checker.sv */
`default_nettype none
`include "keypad_scan_debounce_4x4_macros.svh"
module kpd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_key_char,
  input wire logic [4:0] out_key_number
);

  `KPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_key_char) && $stable(out_key_number), "stalled result changed")
  `KPD_ASSERT_NOW(a_num_range, out_valid, (out_key_number >= 5'd1) && (out_key_number <= 5'd16), "key number out of range")
  `KPD_ASSERT_NOW(a_char_first, out_valid && (out_key_number == 5'd1), out_key_char == 8'h31, "wrong code for key one")
  `KPD_ASSERT_NOW(a_char_last, out_valid && (out_key_number == 5'd16), out_key_char == 8'h14, "wrong code for key sixteen")

endmodule

bind keypad_scan_debounce_4x4 kpd_checker u_kpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_key_char   (out_key_char),
  .out_key_number (out_key_number)
);
`default_nettype wire

/* tb/keypad_scan_debounce_4x4_test.sv */
`default_nettype none
module keypad_scan_debounce_4x4_test import kpd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SCANS = 2000;
  localparam int IDLE_LIMIT   = 300;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [KPD_CHAR_W-1:0] KEY_CHARS [16] = '{
    "1", "2", "3", KPD_DC1, "4", "5", "6", KPD_DC2,
    "7", "8", "9", KPD_DC3, "*", "0", "#", KPD_DC4
  };

  typedef struct packed {
    logic [KPD_CHAR_W-1:0] key_char;
    logic [KPD_KEY_W-1:0]  key_number;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KPD_SNAP_W-1:0] in_pressed_keys = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KPD_CHAR_W-1:0] out_key_char;
  logic [KPD_KEY_W-1:0]  out_key_number;

  logic [KPD_SNAP_W-1:0] pending_scans [$];
  key_event_t            verified_keys [$];
  kpd_phase_t            debounce_phase = PH_RELEASED;
  logic [KPD_KEY_W-1:0]  prior_key = KPD_NO_KEY;
  int                    scans_total = 0;
  int                    scans_taken = 0;
  int                    mismatches = 0;
  int                    idle_cycles = 0;
  int                    scan_gap = 0;
  int                    stall_left = 0;
  bit                    in_quiet = 1'b0;
  bit                    out_quiet = 1'b0;

  keypad_scan_debounce_4x4 i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pressed_keys(in_pressed_keys),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_char   (out_key_char),
    .out_key_number (out_key_number)
  );

  always #5 clk = ~clk;

  // Topmost row wins, then the highest column within it.
  function automatic logic [KPD_KEY_W-1:0] top_key(input logic [KPD_SNAP_W-1:0] snap);
    logic [KPD_KEY_W-1:0] key;
    key = KPD_NO_KEY;
    for (int row = 0; row < 4; row++) begin
      for (int col = 3; col >= 0; col--) begin
        if (key == KPD_NO_KEY && snap[4*row+col]) begin
          key = KPD_KEY_W'(4 * row + col + 1);
        end
      end
    end
    return key;
  endfunction

  function automatic void advance_debounce(input logic [KPD_SNAP_W-1:0] snap);
    logic [KPD_KEY_W-1:0] key;
    key_event_t           ev;
    key = top_key(snap);
    case (debounce_phase)
      PH_RELEASED: begin
        if (key != KPD_NO_KEY) begin
          debounce_phase = PH_EDGE;
        end
      end
      PH_EDGE: begin
        if (key == KPD_NO_KEY) begin
          debounce_phase = PH_RELEASED;
        end else if (key == prior_key) begin
          debounce_phase = PH_VERIFIED;
          ev.key_char = KEY_CHARS[4'(key - 5'd1)];
          ev.key_number = key;
          verified_keys.push_back(ev);
        end
      end
      PH_VERIFIED: begin
        if (key == KPD_NO_KEY || key != prior_key) begin
          debounce_phase = PH_RELEASED;
        end
      end
      default: begin
        debounce_phase = PH_RELEASED;
      end
    endcase
    prior_key = key;
  endfunction

  // A press of one key, with random keys of lower priority held as well.
  function automatic logic [KPD_SNAP_W-1:0] press_snapshot(input int key_idx);
    int row;
    int col;
    int shadow;
    row = key_idx / 4;
    col = key_idx % 4;
    shadow = (((1 << col) - 1) << (4 * row)) | (32'hFFFF << (4 * (row + 1)));
    return KPD_SNAP_W'((1 << key_idx) | (shadow & int'($urandom_range(0, 16'hFFFF))));
  endfunction

  function automatic void queue_scan(input logic [KPD_SNAP_W-1:0] snap);
    pending_scans.push_back(snap);
    scans_total++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_debounce(in_pressed_keys);
        scans_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (scan_gap > 0) begin
          scan_gap--;
          in_valid <= 1'b0;
        end else if (pending_scans.size() > 0) begin
          in_valid <= 1'b1;
          in_pressed_keys <= pending_scans.pop_front();
          if ($urandom_range(0, 49) == 0) begin
            in_quiet = !in_quiet;
          end
          scan_gap = in_quiet ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    key_event_t exp_ev;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verified_keys.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected key transfer: char %h number %0d",
                     $realtime, out_key_char, out_key_number);
          end
          mismatches++;
        end else begin
          exp_ev = verified_keys.pop_front();
          if (out_key_char !== exp_ev.key_char) begin
            if (mismatches < 10) begin
              $display("%0t: key_char expected %h, got %h", $realtime,
                       exp_ev.key_char, out_key_char);
            end
            mismatches++;
          end
          if (out_key_number !== exp_ev.key_number) begin
            if (mismatches < 10) begin
              $display("%0t: key_number expected %0d, got %0d", $realtime,
                       exp_ev.key_number, out_key_number);
            end
            mismatches++;
          end
        end
        if ($urandom_range(0, 49) == 0) begin
          out_quiet = !out_quiet;
        end
        stall_left = out_quiet ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int key_idx;
    int choice;
    // Directed scans: all keys at once, plain presses, key changes during the
    // edge phase, release during the edge phase, and several keys per row.
    queue_scan(16'h0000);
    queue_scan(16'hFFFF);
    queue_scan(16'hFFFF);
    queue_scan(16'h0000);
    queue_scan(16'h0001);
    queue_scan(16'h0001);
    queue_scan(16'h0001);
    queue_scan(16'h0002);
    queue_scan(16'h0002);
    queue_scan(16'h8000);
    queue_scan(16'h4000);
    queue_scan(16'h4000);
    queue_scan(16'h0000);
    queue_scan(16'h0800);
    queue_scan(16'h0000);
    queue_scan(16'h0800);
    queue_scan(16'h0F00);
    queue_scan(16'h0010);
    queue_scan(16'h0030);
    queue_scan(16'h00F0);
    queue_scan(16'h8421);
    queue_scan(16'h7FFF);
    queue_scan(16'hFFFE);
    queue_scan(16'h1000);
    queue_scan(16'h1000);
    queue_scan(16'h0000);

    // Mostly held keys with random shadow keys, some raw noise.
    while (scans_total < RANDOM_SCANS + 26) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        key_idx = $urandom_range(0, 15);
        repeat ($urandom_range(1, 4)) begin
          queue_scan(press_snapshot(key_idx));
        end
        repeat ($urandom_range(0, 2)) begin
          queue_scan(16'h0000);
        end
      end else if (choice < 9) begin
        queue_scan(KPD_SNAP_W'($urandom_range(0, 16'hFFFF)));
      end else begin
        queue_scan(16'h0000);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (scans_taken < scans_total) begin
      @(posedge clk);
    end
    while (verified_keys.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && verified_keys.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/kpd_pkg.sv
rtl/kpd_front.sv
rtl/kpd_queue.sv
rtl/kpd_back.sv
rtl/keypad_scan_debounce_4x4.sv
rtl/kpd_checker.sv
tb/keypad_scan_debounce_4x4_test.sv
